/* sv/cop_pkg.sv */
// Shared types, widths, register indexes and helper functions of the circle
// outline point generator. No dependencies.
package cop_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int COORD_W    = 16;
  localparam int RAD_W      = 14;
  localparam int COLOR_W    = 24;
  localparam int DIM_W      = 13;
  localparam int PIX_W      = 12;
  localparam int CH_W       = 8;
  localparam int LIM_W      = $clog2(MAX_DIM + 1);
  localparam int ROOT_W     = RAD_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int N_W        = 2 * RAD_W;
  localparam int Q_W        = ROOT_W + 1;
  localparam int PT_W       = COORD_W + 2;
  localparam int SQ_STAGES  = ROOT_W / 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COLOR_W;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hff;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 3'd5;

  typedef struct packed {
    logic [COORD_W-1:0] center_col;
    logic [COORD_W-1:0] center_row;
    logic [RAD_W-1:0]   radius;
    logic [COLOR_W-1:0] color;
    logic [DIM_W-1:0]   image_cols;
    logic [DIM_W-1:0]   image_rows;
  } cfg_t;

  // Sideband that rides along with each item through the pipeline
  typedef struct packed {
    logic               by_row;
    logic [PIX_W-1:0]   coord;
    logic [COORD_W-1:0] c_other;
    logic [LIM_W-1:0]   lim_other;
  } ctx_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  function automatic logic [LIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] dim);
    logic [31:0] wide;
    wide = 32'(dim);
    if (wide > 32'(MAX_DIM)) return LIM_W'(MAX_DIM);
    else return LIM_W'(dim);
  endfunction

  // One digit of the restoring square root: bring in two radicand bits,
  // try subtracting 4*root+1.
  function automatic sq_t isqrt_step(input logic [REM_W-1:0] rem,
                                     input logic [ROOT_W-1:0] root,
                                     input logic [1:0] pair);
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    sq_t              res;
    cur   = {rem[REM_W-3:0], pair};
    trial = REM_W'({root, 2'b01});
    if (cur >= trial) begin
      res.rem  = cur - trial;
      res.root = {root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = cur;
      res.root = {root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

/* sv/cop_span.sv */
// Front stages: distance from the center along the sweep axis and the
// span and image checks. Depends on cop_pkg.
module cop_span import cop_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic               command_i,
  input  logic [COORD_W-1:0] sweep_coord_i,
  input  cfg_t               cfg_i,
  output logic               vld_o,
  output logic [RAD_W-1:0]   ad_o,
  output ctx_t               ctx_o
);

  logic [COORD_W-1:0] c_sweep;
  logic [LIM_W-1:0]   lim_sweep;
  logic [COORD_W:0]   d;
  logic               coord_ok;
  ctx_t               ctx_a;

  logic               va_q;
  logic [COORD_W:0]   d_q;
  logic               cok_q;
  ctx_t               ctx_a_q;

  logic [COORD_W:0]   ad;
  logic               span_ok;

  logic               vb_q;
  logic [RAD_W-1:0]   ad_q;
  ctx_t               ctx_b_q;

  // stage A: signed distance and image check of the coordinate
  always_comb begin
    c_sweep   = command_i ? cfg_i.center_row : cfg_i.center_col;
    lim_sweep = clamp_dim(command_i ? cfg_i.image_rows : cfg_i.image_cols);
    d         = {sweep_coord_i[COORD_W-1], sweep_coord_i} - {c_sweep[COORD_W-1], c_sweep};
    coord_ok  = !sweep_coord_i[COORD_W-1] &&
                ({1'b0, sweep_coord_i[COORD_W-2:0]} < COORD_W'(lim_sweep));
    ctx_a.by_row    = command_i;
    ctx_a.coord     = sweep_coord_i[PIX_W-1:0];
    ctx_a.c_other   = command_i ? cfg_i.center_col : cfg_i.center_row;
    ctx_a.lim_other = clamp_dim(command_i ? cfg_i.image_cols : cfg_i.image_rows);
  end

  // stage B: magnitude and span check
  always_comb begin
    ad      = d_q[COORD_W] ? (~d_q + (COORD_W+1)'(1)) : d_q;
    span_ok = ad <= (COORD_W+1)'(cfg_i.radius);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= vld_i;
      vb_q <= va_q && cok_q && span_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q     <= d;
      cok_q   <= coord_ok;
      ctx_a_q <= ctx_a;
      ad_q    <= ad[RAD_W-1:0];
      ctx_b_q <= ctx_a_q;
    end
  end

  assign vld_o = vb_q;
  assign ad_o  = ad_q;
  assign ctx_o = ctx_b_q;

endmodule

/* sv/cop_square.sv */
// Radicand stages: r*r and d*d, then their difference.
// Depends on cop_pkg.
module cop_square import cop_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [RAD_W-1:0] ad_i,
  input  logic [RAD_W-1:0] radius_i,
  input  ctx_t             ctx_i,
  output logic             vld_o,
  output logic [N_W-1:0]   n_o,
  output ctx_t             ctx_o
);

  logic           vc_q, vd_q;
  logic [N_W-1:0] rr_q, dd_q, n_q;
  ctx_t           ctx_c_q, ctx_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= vld_i;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rr_q    <= N_W'(radius_i) * N_W'(radius_i);
      dd_q    <= N_W'(ad_i) * N_W'(ad_i);
      ctx_c_q <= ctx_i;
      n_q     <= rr_q - dd_q;   // d is within the span, no underflow
      ctx_d_q <= ctx_c_q;
    end
  end

  assign vld_o = vd_q;
  assign n_o   = n_q;
  assign ctx_o = ctx_d_q;

endmodule

/* sv/cop_isqrt.sv */
// Pipelined integer square root, two digits per stage, with a final
// round-to-nearest stage. Depends on cop_pkg.
module cop_isqrt import cop_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [N_W-1:0] n_i,
  input  ctx_t           ctx_i,
  output logic           vld_o,
  output logic [Q_W-1:0] q_o,
  output ctx_t           ctx_o
);

  logic              vld_q  [SQ_STAGES];
  logic [REM_W-1:0]  rem_q  [SQ_STAGES];
  logic [ROOT_W-1:0] root_q [SQ_STAGES];
  logic [N_W-1:0]    n_q    [SQ_STAGES];
  ctx_t              ctx_q  [SQ_STAGES];

  logic              vr_q;
  logic [Q_W-1:0]    q_q;
  ctx_t              ctx_r_q;

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    localparam int I0 = ROOT_W - 1 - 2 * k;
    localparam int I1 = I0 - 1;

    logic              v_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [N_W-1:0]    n_in;
    ctx_t              ctx_in;
    sq_t               s0, s1;

    if (k == 0) begin : g_first
      assign v_in    = vld_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = n_i;
      assign ctx_in  = ctx_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign n_in    = n_q[k-1];
      assign ctx_in  = ctx_q[k-1];
    end

    always_comb begin
      s0 = isqrt_step(rem_in, root_in, n_in[2*I0+1 -: 2]);
      s1 = isqrt_step(s0.rem, s0.root, n_in[2*I1+1 -: 2]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= s1.rem;
        root_q[k] <= s1.root;
        n_q[k]    <= n_in;
        ctx_q[k]  <= ctx_in;
      end
    end
  end

  // remainder is n - root^2; round up when it exceeds root
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (en_i) begin
      vr_q <= vld_q[SQ_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (rem_q[SQ_STAGES-1] > REM_W'(root_q[SQ_STAGES-1])) begin
        q_q <= Q_W'(root_q[SQ_STAGES-1]) + Q_W'(1);
      end else begin
        q_q <= Q_W'(root_q[SQ_STAGES-1]);
      end
      ctx_r_q <= ctx_q[SQ_STAGES-1];
    end
  end

  assign vld_o = vr_q;
  assign q_o   = q_q;
  assign ctx_o = ctx_r_q;

endmodule

/* sv/cop_emit.sv */
// Point placement and output buffer: forms center +/- root, drops points
// outside the image and sends up to two beats. Depends on cop_pkg.
module cop_emit import cop_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic [Q_W-1:0]     q_i,
  input  ctx_t               ctx_i,
  input  logic [COLOR_W-1:0] color_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PIX_W-1:0]   pixel_col_o,
  output logic [PIX_W-1:0]   pixel_row_o,
  output logic [CH_W-1:0]    red_o,
  output logic [CH_W-1:0]    green_o,
  output logic [CH_W-1:0]    blue_o,
  output logic [CH_W-1:0]    alpha_o,
  output logic               last_o
);

  logic [PT_W-1:0]  c_ext, p0, p1, lim_ext;
  logic             p0_ok, p1_ok;
  logic             beat, free;
  logic [1:0]       pend_d, pend_q;
  logic [PIX_W-1:0] p0_q, p1_q, coord_q, other;
  logic             by_row_q;

  always_comb begin
    c_ext   = {{(PT_W-COORD_W){ctx_i.c_other[COORD_W-1]}}, ctx_i.c_other};
    lim_ext = PT_W'(ctx_i.lim_other);
    p0      = c_ext + PT_W'(q_i);
    p1      = c_ext - PT_W'(q_i);
    p0_ok   = !p0[PT_W-1] && (p0 < lim_ext);
    p1_ok   = !p1[PT_W-1] && (p1 < lim_ext);
  end

  // pend_q[0]: plus point still to send, pend_q[1]: minus point
  always_comb begin
    beat = (pend_q != 2'b00) && !out_stall_i;
    free = (pend_q == 2'b00) || (beat && (pend_q != 2'b11));
    if (free) begin
      pend_d = vld_i ? {p1_ok, p0_ok} : 2'b00;
    end else if (beat) begin
      pend_d = 2'b10;
    end else begin
      pend_d = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'b00;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free) begin
      p0_q     <= p0[PIX_W-1:0];
      p1_q     <= p1[PIX_W-1:0];
      coord_q  <= ctx_i.coord;
      by_row_q <= ctx_i.by_row;
    end
  end

  assign other       = pend_q[0] ? p0_q : p1_q;
  assign free_o      = free;
  assign out_valid_o = (pend_q != 2'b00);
  assign last_o      = (pend_q != 2'b11);
  assign pixel_col_o = by_row_q ? other : coord_q;
  assign pixel_row_o = by_row_q ? coord_q : other;
  assign red_o       = color_i[23:16];
  assign green_o     = color_i[15:8];
  assign blue_o      = color_i[7:0];
  assign alpha_o     = ALPHA_OPAQUE;

endmodule

/* sv/circle_outline_point_generator.sv */
// Top level of the circle outline point generator: configuration registers
// and the pipeline. Depends on cop_pkg, cop_span, cop_square, cop_isqrt, cop_emit.
//
// Usage:
//   Write the six registers through cfg_we_i / cfg_idx_i / cfg_data_i while
//   the block is idle (center col/row, radius, color, image cols/rows).
//   Each input beat (command_i, sweep_coord_i) is taken when in_valid_i is
//   high and in_stall_o is low. It yields zero, one or two output beats,
//   plus point first, then minus point; last_o marks the final beat of an
//   item. Items that give nothing produce no beat at all.
//   Path: after its input beat is taken, an item passes 2 span stages,
//   2 square stages, 7 root stages, 1 rounding stage, then the output
//   buffer, which shows its first output beat.
//   Throughput: one item per cycle while items yield at most one pixel and
//   out_stall_i is low; an item with both pixels holds the pipeline until
//   its plus point is sent, set by the single output port draining the buffer.
//   Stall: all pipeline stages advance together only when the output buffer
//   can take a new item; out_stall_i holding a beat freezes the pipeline
//   and raises in_stall_o, nothing is lost or repeated.
//   Reset: asynchronous, active low; clears all valid bits and the
//   configuration registers to zero.
module circle_outline_point_generator import cop_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [COORD_W-1:0]    sweep_coord_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      pixel_col_o,
  output logic [PIX_W-1:0]      pixel_row_o,
  output logic [CH_W-1:0]       red_o,
  output logic [CH_W-1:0]       green_o,
  output logic [CH_W-1:0]       blue_o,
  output logic [CH_W-1:0]       alpha_o,
  output logic                  last_o
);

  cfg_t cfg_q;

  // pipeline advance, shared by every stage
  logic adv;

  logic             span_vld;
  logic [RAD_W-1:0] span_ad;
  ctx_t             span_ctx;
  logic             sq_vld;
  logic [N_W-1:0]   sq_n;
  ctx_t             sq_ctx;
  logic             rt_vld;
  logic [Q_W-1:0]   rt_q;
  ctx_t             rt_ctx;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER_COL: cfg_q.center_col <= cfg_data_i[COORD_W-1:0];
        REG_CENTER_ROW: cfg_q.center_row <= cfg_data_i[COORD_W-1:0];
        REG_RADIUS:     cfg_q.radius     <= cfg_data_i[RAD_W-1:0];
        REG_COLOR:      cfg_q.color      <= cfg_data_i[COLOR_W-1:0];
        REG_IMAGE_COLS: cfg_q.image_cols <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_ROWS: cfg_q.image_rows <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = !adv;

  cop_span u_span (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .vld_i         (in_valid_i),
    .command_i     (command_i),
    .sweep_coord_i (sweep_coord_i),
    .cfg_i         (cfg_q),
    .vld_o         (span_vld),
    .ad_o          (span_ad),
    .ctx_o         (span_ctx)
  );

  cop_square u_square (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .vld_i    (span_vld),
    .ad_i     (span_ad),
    .radius_i (cfg_q.radius),
    .ctx_i    (span_ctx),
    .vld_o    (sq_vld),
    .n_o      (sq_n),
    .ctx_o    (sq_ctx)
  );

  cop_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (sq_vld),
    .n_i    (sq_n),
    .ctx_i  (sq_ctx),
    .vld_o  (rt_vld),
    .q_o    (rt_q),
    .ctx_o  (rt_ctx)
  );

  cop_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (rt_vld),
    .q_i         (rt_q),
    .ctx_i       (rt_ctx),
    .color_i     (cfg_q.color),
    .free_o      (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_col_o (pixel_col_o),
    .pixel_row_o (pixel_row_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .alpha_o     (alpha_o),
    .last_o      (last_o)
  );

endmodule

/* sv/cop_checker.sv */
// Port-level checks of the circle outline point generator, bound to the top
// level. Depends on cop_pkg.
module cop_checker import cop_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [PIX_W-1:0]      pixel_col_o,
  input logic [PIX_W-1:0]      pixel_row_o,
  input logic                  last_o
);

  // a held beat keeps its pixel
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_col_o) &&
      $stable(pixel_row_o) && $stable(last_o))
    else $error("stalled output beat changed");

  // a first beat that is taken is always followed at once by the closing beat
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o && !out_stall_i |=> out_valid_o && last_o)
    else $error("second beat of a pixel pair missing");

  // empty output buffer means the input side is open
  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // a blocked output beat freezes the pipeline
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output blocked");

endmodule

bind circle_outline_point_generator cop_checker u_cop_checker (.*);
